// File: sv/wnpm_pkg.sv
// shared types, widths and constants for the weighted nearest palette match block
`default_nettype none

package wnpm_pkg;

	localparam int DEFAULT_PALETTE_DEPTH = 512;

	localparam int IDX_W    = 9;
	localparam int CHAN_W   = 8;
	localparam int COLOR_W  = 24;
	localparam int CFG_W    = 10;
	localparam int DIST_W   = 23;
	localparam int SQ_W     = 16;
	localparam int WEIGHT_W = 7;
	localparam int WSQ_W    = 22;
	localparam int S_DATA_W = 64;
	localparam int M_DATA_W = 32;

	// luminance weights, scaled by 100
	localparam logic [WEIGHT_W-1:0] WEIGHT_RED   = 7'd30;
	localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN = 7'd59;
	localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE  = 7'd11;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		CH_RED,
		CH_GREEN,
		CH_BLUE
	} chan_t;

	typedef struct packed {
		logic               enabled;
		logic [COLOR_W-1:0] rgb;
	} palette_word_t;

	function automatic logic [WEIGHT_W-1:0] channel_weight(input chan_t ch);
		logic [WEIGHT_W-1:0] w;
		case (ch)
			CH_RED:   w = WEIGHT_RED;
			CH_GREEN: w = WEIGHT_GREEN;
			CH_BLUE:  w = WEIGHT_BLUE;
			default:  w = '0;
		endcase
		return w;
	endfunction

	function automatic logic [CHAN_W-1:0] channel_of(input logic [COLOR_W-1:0] rgb,
		input chan_t ch);
		logic [CHAN_W-1:0] c;
		case (ch)
			CH_RED:   c = rgb[23:16];
			CH_GREEN: c = rgb[15:8];
			CH_BLUE:  c = rgb[7:0];
			default:  c = '0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// File: sv/weighted_nearest_palette_match.sv
// top level of the weighted nearest palette match block
`default_nettype none

// Palette store with a weighted nearest-color search. A write transaction (tuser = 0) loads
// or disables one palette slot and returns nothing; slots at or above
// PALETTE_DEPTH are ignored. A query transaction (tuser = 1) scans slots 0 to
// min(entries_in_use, PALETTE_DEPTH)-1, skips disabled ones, and returns the first slot with
// the strictly smallest 30*dr^2 + 59*dg^2 + 11*db^2, with tuser (found) low and zeros in
// tdata when no enabled slot was scanned. One squaring and weighting unit is shared by the
// three channels, so a query makes three unit passes per slot through the read and
// arithmetic pipeline, and an empty range goes straight to the result; input is held off
// during a query.
// After reset the enabled bits are cleared by a sweep over all PALETTE_DEPTH slots, one slot a
// cycle, before the first transaction is taken. A finished result sits in an output
// register, so write transactions keep flowing while it waits to be taken.
module weighted_nearest_palette_match #(
	parameter int PALETTE_DEPTH = wnpm_pkg::DEFAULT_PALETTE_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input stream
	input  wire logic                          s_axis_tvalid,
	output      logic                          s_axis_tready,
	// entry_index, entry_red, entry_green, entry_blue, entry_enabled, query_rgb, zero pad
	input  wire logic [wnpm_pkg::S_DATA_W-1:0] s_axis_tdata,
	// op
	input  wire logic                          s_axis_tuser,
	// result stream
	output      logic                          m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// best_index, best_distance
	output      logic [wnpm_pkg::M_DATA_W-1:0] m_axis_tdata,
	// found
	output      logic                          m_axis_tuser,
	// entries_in_use register
	input  wire logic                          cfg_wr_en,
	input  wire logic [wnpm_pkg::CFG_W-1:0]    cfg_wr_data
);

	localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(PALETTE_DEPTH + 1);

	// unpacked input fields
	logic [wnpm_pkg::IDX_W-1:0]   in_entry_index;
	logic [wnpm_pkg::CHAN_W-1:0]  in_entry_red;
	logic [wnpm_pkg::CHAN_W-1:0]  in_entry_green;
	logic [wnpm_pkg::CHAN_W-1:0]  in_entry_blue;
	logic                         in_entry_enabled;
	logic [wnpm_pkg::COLOR_W-1:0] in_query_rgb;

	assign in_entry_index   = s_axis_tdata[8:0];
	assign in_entry_red     = s_axis_tdata[16:9];
	assign in_entry_green   = s_axis_tdata[24:17];
	assign in_entry_blue    = s_axis_tdata[32:25];
	assign in_entry_enabled = s_axis_tdata[33];
	assign in_query_rgb     = s_axis_tdata[57:34];

	wnpm_pkg::state_t state_q, state_d;

	logic in_xact;
	logic query_xact;
	logic write_xact;
	logic clearing;
	logic issue_en;
	logic out_load;
	logic scan_end;
	logic out_free;

	// configuration and per-query registers
	logic [wnpm_pkg::CFG_W-1:0]   entries_in_use_q;
	logic [CNT_W-1:0]             limit_d;
	logic [CNT_W-1:0]             limit_q;
	logic [wnpm_pkg::COLOR_W-1:0] query_rgb_q;

	// sequencer
	logic [ADDR_W-1:0]    clr_addr_q;
	logic [ADDR_W-1:0]    idx_q;
	wnpm_pkg::chan_t      ch_q;
	logic                 issuing_q;
	logic                 last_issue;

	// palette memory, enabled bit stored beside the color
	wnpm_pkg::palette_word_t mem [PALETTE_DEPTH];
	logic                    mem_we;
	logic [ADDR_W-1:0]       mem_waddr;
	wnpm_pkg::palette_word_t mem_wdata;

	// pipeline
	logic                         v_s1, v_s2, v_s3;
	logic                         last_s1, last_s2, last_s3;
	wnpm_pkg::chan_t              ch_s1, ch_s2, ch_s3;
	logic [ADDR_W-1:0]            idx_s1, idx_s2, idx_s3;
	logic                         en_s2, en_s3;
	wnpm_pkg::palette_word_t      word_s1;
	logic [wnpm_pkg::SQ_W-1:0]    sq_s2;
	logic [wnpm_pkg::WSQ_W-1:0]   wsq_s3;

	logic [wnpm_pkg::CHAN_W-1:0]  chan_a;
	logic [wnpm_pkg::CHAN_W-1:0]  chan_b;
	logic [wnpm_pkg::CHAN_W-1:0]  diff;
	logic [wnpm_pkg::SQ_W-1:0]    sq_d;
	logic [wnpm_pkg::WEIGHT_W-1:0] weight;
	logic [wnpm_pkg::WSQ_W-1:0]   wsq_d;

	// accumulator and running best
	logic [wnpm_pkg::DIST_W-1:0]  acc_q;
	logic [wnpm_pkg::DIST_W-1:0]  dist_sum;
	logic                         take;
	logic                         best_found_q;
	logic [ADDR_W-1:0]            best_idx_q;
	logic [wnpm_pkg::DIST_W-1:0]  best_dist_q;

	// output register
	logic                         out_valid_q;
	logic                         out_found_q;
	logic [wnpm_pkg::IDX_W-1:0]   out_idx_q;
	logic [wnpm_pkg::DIST_W-1:0]  out_dist_q;

	// handshake decode
	assign in_xact    = s_axis_tvalid && s_axis_tready;
	assign query_xact = in_xact && (s_axis_tuser == wnpm_pkg::OP_QUERY);
	assign write_xact = in_xact && (s_axis_tuser == wnpm_pkg::OP_WRITE);
	assign out_free   = !out_valid_q || m_axis_tready;

	// scan length, saturated to the store depth
	assign limit_d = (32'(entries_in_use_q) > 32'(PALETTE_DEPTH)) ?
		CNT_W'(PALETTE_DEPTH) : CNT_W'(entries_in_use_q);

	assign last_issue = (CNT_W'(idx_q) + CNT_W'(1)) == limit_q;

	// last channel of the last slot leaves the accumulator
	assign scan_end = v_s3 && last_s3 && (ch_s3 == wnpm_pkg::CH_BLUE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			wnpm_pkg::ST_CLEAR: begin
				if (clr_addr_q == ADDR_W'(PALETTE_DEPTH - 1)) begin
					state_d = wnpm_pkg::ST_IDLE;
				end
			end
			wnpm_pkg::ST_IDLE: begin
				if (query_xact) begin
					// an empty scan range goes straight to the result
					state_d = (limit_d == '0) ? wnpm_pkg::ST_DONE : wnpm_pkg::ST_SCAN;
				end
			end
			wnpm_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = wnpm_pkg::ST_DONE;
				end
			end
			wnpm_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = wnpm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wnpm_pkg::ST_CLEAR;
			end
		endcase
	end

	// state outputs
	always_comb begin
		s_axis_tready = 1'b0;
		clearing      = 1'b0;
		issue_en      = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			wnpm_pkg::ST_CLEAR: clearing      = 1'b1;
			wnpm_pkg::ST_IDLE:  s_axis_tready = 1'b1;
			wnpm_pkg::ST_SCAN:  issue_en      = issuing_q;
			wnpm_pkg::ST_DONE:  out_load      = out_free;
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wnpm_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_in_use_q <= '0;
		end else if (cfg_wr_en) begin
			entries_in_use_q <= cfg_wr_data;
		end
	end

	// clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (clearing) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end
	end

	// memory write port: clearing sweep or a write transaction inside the store
	assign mem_we = clearing ||
		(write_xact && (32'(in_entry_index) < 32'(PALETTE_DEPTH)));
	assign mem_waddr = clearing ? clr_addr_q : ADDR_W'(in_entry_index);
	always_comb begin
		mem_wdata.enabled = clearing ? 1'b0 : in_entry_enabled;
		mem_wdata.rgb     = {in_entry_red, in_entry_green, in_entry_blue};
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		word_s1 <= mem[idx_q];
	end

	// per-query latch
	always_ff @(posedge clk) begin
		if (query_xact) begin
			query_rgb_q <= in_query_rgb;
			limit_q     <= limit_d;
		end
	end

	// sequencer: three channel passes per slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			ch_q      <= wnpm_pkg::CH_RED;
			issuing_q <= 1'b0;
		end else if (query_xact) begin
			idx_q     <= '0;
			ch_q      <= wnpm_pkg::CH_RED;
			issuing_q <= (limit_d != '0);
		end else if (issue_en) begin
			case (ch_q)
				wnpm_pkg::CH_RED:   ch_q <= wnpm_pkg::CH_GREEN;
				wnpm_pkg::CH_GREEN: ch_q <= wnpm_pkg::CH_BLUE;
				default: begin
					ch_q <= wnpm_pkg::CH_RED;
					if (last_issue) begin
						issuing_q <= 1'b0;
					end else begin
						idx_q <= idx_q + ADDR_W'(1);
					end
				end
			endcase
		end
	end

	// pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: memory word arrives, square the channel difference
	assign chan_a = wnpm_pkg::channel_of(word_s1.rgb, ch_s1);
	assign chan_b = wnpm_pkg::channel_of(query_rgb_q, ch_s1);
	assign diff   = (chan_a > chan_b) ? (chan_a - chan_b) : (chan_b - chan_a);
	assign sq_d   = {{(wnpm_pkg::SQ_W - wnpm_pkg::CHAN_W){1'b0}}, diff} *
		{{(wnpm_pkg::SQ_W - wnpm_pkg::CHAN_W){1'b0}}, diff};

	// stage 2: apply the channel weight
	assign weight = wnpm_pkg::channel_weight(ch_s2);
	assign wsq_d  = {{(wnpm_pkg::WSQ_W - wnpm_pkg::SQ_W){1'b0}}, sq_s2} *
		{{(wnpm_pkg::WSQ_W - wnpm_pkg::WEIGHT_W){1'b0}}, weight};

	always_ff @(posedge clk) begin
		ch_s1   <= ch_q;
		idx_s1  <= idx_q;
		last_s1 <= last_issue;

		sq_s2   <= sq_d;
		ch_s2   <= ch_s1;
		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
		en_s2   <= word_s1.enabled;

		wsq_s3  <= wsq_d;
		ch_s3   <= ch_s2;
		idx_s3  <= idx_s2;
		last_s3 <= last_s2;
		en_s3   <= en_s2;
	end

	// stage 3: accumulate channels, compare on the last one
	assign dist_sum = acc_q + {{(wnpm_pkg::DIST_W - wnpm_pkg::WSQ_W){1'b0}}, wsq_s3};
	// ties keep the earlier slot
	assign take = v_s3 && (ch_s3 == wnpm_pkg::CH_BLUE) && en_s3 &&
		(!best_found_q || (dist_sum < best_dist_q));

	always_ff @(posedge clk) begin
		if (v_s3) begin
			if (ch_s3 == wnpm_pkg::CH_RED) begin
				acc_q <= {{(wnpm_pkg::DIST_W - wnpm_pkg::WSQ_W){1'b0}}, wsq_s3};
			end else begin
				acc_q <= dist_sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q <= 1'b0;
		end else if (query_xact) begin
			best_found_q <= 1'b0;
		end else if (take) begin
			best_found_q <= 1'b1;
		end
	end

	// zeroed per query so a miss reports zeros
	always_ff @(posedge clk) begin
		if (query_xact) begin
			best_idx_q  <= '0;
			best_dist_q <= '0;
		end else if (take) begin
			best_idx_q  <= idx_s3;
			best_dist_q <= dist_sum;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_found_q <= best_found_q;
			out_idx_q   <= wnpm_pkg::IDX_W'(best_idx_q);
			out_dist_q  <= best_dist_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tdata  = {out_dist_q, out_idx_q};

endmodule

`default_nettype wire
